>>> hdl/srg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srg_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW      = 4;
  localparam int CntW      = 5;
  localparam int PosW      = 17;
  localparam logic [PosW-1:0] PosOne = 17'h10000;

  localparam logic [2:0] CFG_SHIFT      = 3'd0;
  localparam logic [2:0] CFG_RANGE_LO   = 3'd1;
  localparam logic [2:0] CFG_RANGE_HI   = 3'd2;
  localparam logic [2:0] CFG_RAMP_WIDTH = 3'd3;
  localparam logic [2:0] CFG_LOW_RED    = 3'd4;
  localparam logic [2:0] CFG_LOW_GREEN  = 3'd5;
  localparam logic [2:0] CFG_LOW_BLUE   = 3'd6;
  localparam logic [2:0] CFG_LOW_ALPHA  = 3'd7;

  typedef logic [3:0][15:0] color_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_NDIV, ST_INS, ST_WINIT, ST_FETCH, ST_DECIDE,
    ST_LR_EMIT, ST_ADV, ST_PK_EMIT, ST_GAP, ST_LOW1, ST_LOW2, ST_MID_EMIT,
    ST_TPEAK, ST_RR_EMIT, ST_BM1, ST_BM2, ST_BDS, ST_BDW
  } state_t;

  typedef enum logic [1:0] {
    BL_LRAMP, BL_MID, BL_RRAMP
  } blsel_t;

  typedef enum logic [2:0] {
    NODE_LRAMP, NODE_PEAK, NODE_LOW1, NODE_LOW2, NODE_MID, NODE_RRAMP
  } node_t;

  typedef struct packed {
    logic   capture;
    logic   t_direct_ld;
    logic   div_norm;
    logic   t_div_ld;
    logic   insert;
    logic   walk_init;
    logic   fetch;
    logic   advance;
    logic   bl_init;
    blsel_t bl_sel;
    logic   mul1;
    logic   mul2;
    logic   div_blend;
    logic   ch_store;
    logic   emit;
    node_t  node;
    logic   emit_last;
    logic   clr_count;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic full;
    logic need_div;
    logic div_done;
    logic walk_end;
    logic have_prev;
    logic e_pos_nz;
    logic dup;
    logic gap_gt2d;
    logic gap_gtd;
    logic a_lt_one;
    logic out_free;
    logic ch_last;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/sawtooth_ramp_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Collects up to 16 colored peaks, one word per load, and on the word marked
// last_point emits the sorted, de-duplicated sawtooth as a stream of nodes.
// A load whose normalized position is 0 or saturates skips the shared
// 16-step radix-2 divider; any other load waits for one pass of it. After
// the last word the block walks the sorted store one entry at a time; each
// node with a blended color takes four channels, each two multiply steps
// and one pass of the same divider. Configuration
// writes take effect at once and must be made while no set is in flight.
module sawtooth_ramp_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] point_pos,
  input  logic [15:0] point_red,
  input  logic [15:0] point_green,
  input  logic [15:0] point_blue,
  input  logic [15:0] point_alpha,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_pos,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  output logic        out_last
);
  import srg_pkg::*;

  cmd_t    cmd;
  status_t sts;

  srg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_pos   (point_pos),
    .point_red   (point_red),
    .point_green (point_green),
    .point_blue  (point_blue),
    .point_alpha (point_alpha),
    .last_point  (last_point),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pos     (out_pos),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

>>> hdl/srg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module srg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] rem0,
  input  logic [15:0] low,
  input  logic [32:0] den,
  output logic        done,
  output logic [15:0] quo
);
  import srg_pkg::*;

  logic        busy;
  logic [3:0]  cnt;
  logic [32:0] rem;
  logic [32:0] den_r;
  logic [15:0] sh;
  logic [33:0] trial;
  logic        qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, sh[15]};
    qbit  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem0;
      sh    <= low;
      den_r <= den;
    end else if (busy) begin
      rem <= qbit ? 33'(trial - {1'b0, den_r}) : trial[32:0];
      sh  <= {sh[14:0], qbit};
    end
  end

  assign quo = sh;

endmodule
`default_nettype wire

>>> hdl/srg_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module srg_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic [31:0]     point_pos,
  input  logic [15:0]     point_red,
  input  logic [15:0]     point_green,
  input  logic [15:0]     point_blue,
  input  logic [15:0]     point_alpha,
  input  logic            last_point,
  input  srg_pkg::cmd_t   cmd,
  output srg_pkg::status_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [16:0]     out_pos,
  output logic [15:0]     out_red,
  output logic [15:0]     out_green,
  output logic [15:0]     out_blue,
  output logic [15:0]     out_alpha,
  output logic            out_last
);
  import srg_pkg::*;

  logic [31:0] shift_amount, range_lo, range_hi;
  logic [16:0] ramp_width;
  color_t      low_col;

  logic [31:0] in_pos;
  color_t      in_col;
  logic        in_last;
  logic [PosW-1:0] t_val;

  logic [PosW-1:0] pos_mem [MaxPoints];
  color_t          col_mem [MaxPoints];
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic            have_prev;
  logic [PosW-1:0] e_pos, a_pos;
  color_t          e_col, a_col;

  blsel_t      bl_sel;
  logic [16:0] bl_n;
  logic [1:0]  ch;
  logic [32:0] acc;
  color_t      bcol;

  logic [16:0] d_eff;
  logic [32:0] p_sum;
  logic [33:0] diffp;
  logic [32:0] den_n;
  logic        range_ok, pos_ok, sat;
  logic [PosW-1:0] t_direct;
  logic [16:0] gap;
  logic [17:0] pn;
  logic [16:0] n_sel;
  logic [16:0] w_a;
  logic [15:0] chan_a, chan_b;
  logic [16:0] hsum;
  logic [MaxPoints-1:0] gt, shv;
  logic [PosW-1:0] pos_prev [MaxPoints];
  color_t          col_prev [MaxPoints];
  logic [PosW-1:0] node_pos;
  color_t          node_col;
  logic            div_start, div_done;
  logic [32:0]     div_rem0, div_den;
  logic [15:0]     div_low, div_q;

  assign d_eff = (ramp_width == 17'd0) ? 17'd1 : ramp_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount <= '0;
      range_lo     <= '0;
      range_hi     <= 32'd65536;
      ramp_width   <= 17'd6554;
      low_col      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHIFT:      shift_amount <= cfg_data;
        CFG_RANGE_LO:   range_lo     <= cfg_data;
        CFG_RANGE_HI:   range_hi     <= cfg_data;
        CFG_RAMP_WIDTH: ramp_width   <= cfg_data[16:0];
        CFG_LOW_RED:    low_col[0]   <= cfg_data[15:0];
        CFG_LOW_GREEN:  low_col[1]   <= cfg_data[15:0];
        CFG_LOW_BLUE:   low_col[2]   <= cfg_data[15:0];
        CFG_LOW_ALPHA:  low_col[3]   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // normalization operands from the captured word
  always_comb begin
    p_sum    = {in_pos[31], in_pos} + {shift_amount[31], shift_amount};
    diffp    = {p_sum[32], p_sum} - {{2{range_lo[31]}}, range_lo};
    den_n    = {range_hi[31], range_hi} - {range_lo[31], range_lo};
    range_ok = $signed(range_hi) > $signed(range_lo);
    pos_ok   = !diffp[33] && (diffp != 34'd0);
    sat      = diffp[32:0] >= den_n;
    t_direct = (range_ok && pos_ok && sat) ? PosOne : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_pos  <= point_pos;
      in_col  <= {point_alpha, point_blue, point_green, point_red};
      in_last <= last_point;
    end
    if (cmd.t_direct_ld) t_val <= t_direct;
    else if (cmd.t_div_ld) t_val <= {1'b0, div_q};
  end

  // stable insertion: new word goes after every entry not above it
  always_comb begin
    for (int j = 0; j < MaxPoints; j++) begin
      gt[j] = (CntW'(j) < count) && (pos_mem[j] > t_val);
    end
    shv = {gt[MaxPoints-2:0], 1'b0};
    pos_prev[0] = t_val;
    col_prev[0] = in_col;
    for (int j = 1; j < MaxPoints; j++) begin
      pos_prev[j] = pos_mem[j-1];
      col_prev[j] = col_mem[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int j = 0; j < MaxPoints; j++) begin
        if (shv[j]) begin
          pos_mem[j] <= pos_prev[j];
          col_mem[j] <= col_prev[j];
        end else if (gt[j] || CntW'(j) == count) begin
          pos_mem[j] <= t_val;
          col_mem[j] <= in_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      have_prev <= 1'b0;
    end else begin
      if (cmd.insert) count <= count + CntW'(1);
      else if (cmd.clr_count) count <= '0;
      if (cmd.walk_init) begin
        idx       <= '0;
        have_prev <= 1'b0;
      end else begin
        if (cmd.fetch) idx <= idx + CntW'(1);
        if (cmd.advance) have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      e_pos <= pos_mem[idx[IdxW-1:0]];
      e_col <= col_mem[idx[IdxW-1:0]];
    end
    if (cmd.advance) begin
      a_pos <= e_pos;
      a_col <= e_col;
    end
  end

  always_comb begin
    gap  = e_pos - a_pos;
    pn   = {1'b0, a_pos} + {1'b0, d_eff};
    hsum = {1'b0, a_col[ch]} + {1'b0, e_col[ch]};
    case (cmd.bl_sel)
      BL_LRAMP: n_sel = (e_pos < d_eff) ? 17'(d_eff - e_pos) : '0;
      BL_MID:   n_sel = gap - d_eff;
      BL_RRAMP: n_sel = (pn > {1'b0, PosOne}) ? 17'(pn - {1'b0, PosOne}) : '0;
      default:  n_sel = '0;
    endcase
    case (bl_sel)
      BL_MID:  chan_a = hsum[16:1];
      default: chan_a = low_col[ch];
    endcase
    case (bl_sel)
      BL_LRAMP: chan_b = e_col[ch];
      BL_RRAMP: chan_b = a_col[ch];
      default:  chan_b = low_col[ch];
    endcase
    w_a = d_eff - bl_n;
  end

  always_ff @(posedge clk) begin
    if (cmd.bl_init) begin
      bl_sel <= cmd.bl_sel;
      bl_n   <= n_sel;
    end
    if (cmd.mul1) acc <= {17'd0, chan_a} * {16'd0, w_a};
    else if (cmd.mul2) acc <= acc + ({17'd0, chan_b} * {16'd0, bl_n});
    if (cmd.ch_store) bcol[ch] <= div_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (cmd.bl_init) begin
      ch <= '0;
    end else if (cmd.ch_store) begin
      ch <= ch + 2'd1;
    end
  end

  assign div_start = cmd.div_norm | cmd.div_blend;
  assign div_rem0  = cmd.div_norm ? diffp[32:0] : {16'd0, acc[32:16]};
  assign div_low   = cmd.div_norm ? 16'd0 : acc[15:0];
  assign div_den   = cmd.div_norm ? den_n : {16'd0, d_eff};

  srg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem0  (div_rem0),
    .low   (div_low),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    node_pos = a_pos;
    node_col = a_col;
    case (cmd.node)
      NODE_LRAMP: begin
        node_pos = (e_pos > d_eff) ? 17'(e_pos - d_eff) : '0;
        node_col = bcol;
      end
      NODE_PEAK: begin
        node_pos = a_pos;
        node_col = a_col;
      end
      NODE_LOW1: begin
        node_pos = pn[16:0];
        node_col = low_col;
      end
      NODE_LOW2: begin
        node_pos = e_pos - d_eff;
        node_col = low_col;
      end
      NODE_MID: begin
        node_pos = 17'(({1'b0, a_pos} + {1'b0, e_pos}) >> 1);
        node_col = bcol;
      end
      NODE_RRAMP: begin
        node_pos = (pn > {1'b0, PosOne}) ? PosOne : pn[16:0];
        node_col = bcol;
      end
      default: ;
    endcase
  end

  // output register: reload as the old word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pos   <= node_pos;
      out_red   <= node_col[0];
      out_green <= node_col[1];
      out_blue  <= node_col[2];
      out_alpha <= node_col[3];
      out_last  <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.in_last   = in_last;
    sts.full      = count == CntW'(MaxPoints);
    sts.need_div  = range_ok && pos_ok && !sat;
    sts.div_done  = div_done;
    sts.walk_end  = idx == count;
    sts.have_prev = have_prev;
    sts.e_pos_nz  = e_pos != '0;
    sts.dup       = (e_pos == a_pos) && (e_col == a_col);
    sts.gap_gt2d  = {1'b0, gap} > {d_eff, 1'b0};
    sts.gap_gtd   = gap > d_eff;
    sts.a_lt_one  = a_pos < PosOne;
    sts.out_free  = !out_valid || out_ready;
    sts.ch_last   = ch == 2'd3;
  end

endmodule
`default_nettype wire

>>> hdl/srg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module srg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  srg_pkg::status_t sts,
  output srg_pkg::cmd_t    cmd
);
  import srg_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.full) begin
          state_next = sts.in_last ? ST_WINIT : ST_IDLE;
        end else if (sts.need_div) begin
          cmd.div_norm = 1'b1;
          state_next   = ST_NDIV;
        end else begin
          cmd.t_direct_ld = 1'b1;
          state_next      = ST_INS;
        end
      end
      ST_NDIV: begin
        if (sts.div_done) begin
          cmd.t_div_ld = 1'b1;
          state_next   = ST_INS;
        end
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_next = sts.in_last ? ST_WINIT : ST_IDLE;
      end
      ST_WINIT: begin
        cmd.walk_init = 1'b1;
        state_next    = ST_FETCH;
      end
      ST_FETCH: begin
        if (sts.walk_end) begin
          state_next = ST_TPEAK;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!sts.have_prev) begin
          if (sts.e_pos_nz) begin
            cmd.bl_init = 1'b1;
            cmd.bl_sel  = BL_LRAMP;
            ret_next    = ST_LR_EMIT;
            state_next  = ST_BM1;
          end else begin
            state_next = ST_ADV;
          end
        end else if (sts.dup) begin
          state_next = ST_FETCH;
        end else begin
          state_next = ST_PK_EMIT;
        end
      end
      ST_LR_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.node   = NODE_LRAMP;
          state_next = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd.advance = 1'b1;
        state_next  = ST_FETCH;
      end
      ST_PK_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.node   = NODE_PEAK;
          state_next = ST_GAP;
        end
      end
      ST_GAP: begin
        if (sts.gap_gt2d) begin
          state_next = ST_LOW1;
        end else if (sts.gap_gtd) begin
          cmd.bl_init = 1'b1;
          cmd.bl_sel  = BL_MID;
          ret_next    = ST_MID_EMIT;
          state_next  = ST_BM1;
        end else begin
          state_next = ST_ADV;
        end
      end
      ST_LOW1: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.node   = NODE_LOW1;
          state_next = ST_LOW2;
        end
      end
      ST_LOW2: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.node   = NODE_LOW2;
          state_next = ST_ADV;
        end
      end
      ST_MID_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.node   = NODE_MID;
          state_next = ST_ADV;
        end
      end
      ST_TPEAK: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.node      = NODE_PEAK;
          cmd.emit_last = !sts.a_lt_one;
          if (sts.a_lt_one) begin
            cmd.bl_init = 1'b1;
            cmd.bl_sel  = BL_RRAMP;
            ret_next    = ST_RR_EMIT;
            state_next  = ST_BM1;
          end else begin
            cmd.clr_count = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      ST_RR_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.node      = NODE_RRAMP;
          cmd.emit_last = 1'b1;
          cmd.clr_count = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_BM1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_BM2;
      end
      ST_BM2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_BDS;
      end
      ST_BDS: begin
        cmd.div_blend = 1'b1;
        state_next    = ST_BDW;
      end
      ST_BDW: begin
        if (sts.div_done) begin
          cmd.ch_store = 1'b1;
          state_next   = sts.ch_last ? ret : ST_BM1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/srg_check.sv
`timescale 1ns / 1ps
`default_nettype none
module srg_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_pos,
  input logic        out_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pos) && $stable(out_last))
    else $error("output word changed while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pos <= 17'h10000)
    else $error("node position above one");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sawtooth_ramp_generator_core srg_check u_srg_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_pos   (out_pos),
  .out_last  (out_last)
);
`default_nettype wire

>>> tb/sv/sawtooth_ramp_generator_core_tb.sv
`timescale 1ns / 1ps
module sawtooth_ramp_generator_core_tb;
  import srg_pkg::color_t;
  import srg_pkg::CFG_SHIFT;
  import srg_pkg::CFG_RANGE_LO;
  import srg_pkg::CFG_RANGE_HI;
  import srg_pkg::CFG_RAMP_WIDTH;
  import srg_pkg::CFG_LOW_RED;
  import srg_pkg::CFG_LOW_GREEN;
  import srg_pkg::CFG_LOW_BLUE;
  import srg_pkg::CFG_LOW_ALPHA;

  localparam int StoreDepth = 16;
  localparam longint OneQ16 = 65536;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 400;

  typedef struct packed {
    logic [16:0] pos;
    color_t      col;
    logic        last;
  } ramp_node_t;

  class sawtooth_scoreboard;
    logic [31:0] shift;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [16:0] width;
    color_t      low;
    longint      pos_st[StoreDepth];
    color_t      col_st[StoreDepth];
    int          cnt;
    ramp_node_t  nodes_q[$];
    int          errors;

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_SHIFT:      shift = data;
        CFG_RANGE_LO:   lo = data;
        CFG_RANGE_HI:   hi = data;
        CFG_RAMP_WIDTH: width = data[16:0];
        CFG_LOW_RED:    low[0] = data[15:0];
        CFG_LOW_GREEN:  low[1] = data[15:0];
        CFG_LOW_BLUE:   low[2] = data[15:0];
        CFG_LOW_ALPHA:  low[3] = data[15:0];
        default: ;
      endcase
    endfunction

    function longint mix(longint x, longint y, longint n, longint d);
      return (x * (d - n) + y * n) / d;
    endfunction

    function color_t ramp_col(color_t peak, longint n, longint d);
      color_t c;
      for (int i = 0; i < 4; i++) c[i] = 16'(mix(low[i], peak[i], n, d));
      return c;
    endfunction

    function void push_node(longint pos, color_t c);
      ramp_node_t nd;
      nd.pos = pos[16:0];
      nd.col = c;
      nd.last = 1'b0;
      nodes_q.push_back(nd);
    endfunction

    // Accepted point: normalize into the store, build the sawtooth on the last one.
    function void note_point(logic [31:0] pp, color_t c, logic lst);
      longint p, l, h, t, d, gap, p0, pc;
      longint sp[StoreDepth];
      color_t sc[StoreDepth];
      color_t mc;
      int n, j, first;
      if (cnt < StoreDepth) begin
        p = longint'($signed(pp)) + longint'($signed(shift));
        l = longint'($signed(lo));
        h = longint'($signed(hi));
        t = 0;
        if (h > l && p > l) begin
          t = ((p - l) <<< 16) / (h - l);
          if (t > OneQ16) t = OneQ16;
        end
        pos_st[cnt] = t;
        col_st[cnt] = c;
        cnt++;
      end
      if (!lst) return;
      n = 0;
      for (int i = 0; i < cnt; i++) begin
        j = n;
        while (j > 0 && sp[j-1] > pos_st[i]) begin
          sp[j] = sp[j-1];
          sc[j] = sc[j-1];
          j--;
        end
        sp[j] = pos_st[i];
        sc[j] = col_st[i];
        n++;
      end
      j = 0;
      for (int i = 0; i < n; i++) begin
        if (j > 0 && sp[j-1] == sp[i] && sc[j-1] == sc[i]) continue;
        sp[j] = sp[i];
        sc[j] = sc[i];
        j++;
      end
      n = j;
      cnt = 0;
      if (n == 0) return;
      first = nodes_q.size();
      d = (width == 0) ? 1 : longint'(width);
      if (sp[0] > 0) begin
        p0 = sp[0] - d;
        pc = (p0 < 0) ? 0 : p0;
        push_node(pc, ramp_col(sc[0], pc - p0, d));
      end
      for (int i = 0; i + 1 < n; i++) begin
        gap = sp[i+1] - sp[i];
        push_node(sp[i], sc[i]);
        if (gap > 2 * d) begin
          push_node(sp[i] + d, low);
          push_node(sp[i+1] - d, low);
        end else if (gap > d) begin
          for (int ch = 0; ch < 4; ch++)
            mc[ch] = 16'(mix((longint'(sc[i][ch]) + longint'(sc[i+1][ch])) >> 1,
                             low[ch], gap - d, d));
          push_node((sp[i] + sp[i+1]) / 2, mc);
        end
      end
      push_node(sp[n-1], sc[n-1]);
      if (sp[n-1] < OneQ16) begin
        p0 = sp[n-1] + d;
        pc = (p0 > OneQ16) ? OneQ16 : p0;
        push_node(pc, ramp_col(sc[n-1], p0 - pc, d));
      end
      if (nodes_q.size() > first) nodes_q[nodes_q.size()-1].last = 1'b1;
    endfunction

    function void check_node(ramp_node_t act);
      ramp_node_t ex;
      if (nodes_q.size() == 0) begin
        $display("%0t: unexpected node pos=%h col=%h last=%b", $time, act.pos, act.col,
                 act.last);
        errors++;
        return;
      end
      ex = nodes_q.pop_front();
      if (act.pos !== ex.pos) begin
        $display("%0t: out_pos expected %h actual %h", $time, ex.pos, act.pos);
        errors++;
      end
      for (int i = 0; i < 4; i++)
        if (act.col[i] !== ex.col[i]) begin
          $display("%0t: color channel %0d expected %h actual %h", $time, i, ex.col[i],
                   act.col[i]);
          errors++;
        end
      if (act.last !== ex.last) begin
        $display("%0t: out_last expected %b actual %b", $time, ex.last, act.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] point_pos;
  logic [15:0] point_red;
  logic [15:0] point_green;
  logic [15:0] point_blue;
  logic [15:0] point_alpha;
  logic        last_point;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] out_pos;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;
  logic        out_last;

  sawtooth_ramp_generator_core u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_pos(point_pos), .point_red(point_red), .point_green(point_green),
    .point_blue(point_blue), .point_alpha(point_alpha), .last_point(last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos(out_pos), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha), .out_last(out_last)
  );

  sawtooth_scoreboard sb;
  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  int  hold_cnt;
  int  cycles;
  logic [31:0] prev_pos;
  color_t      prev_col;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check on handshake, then pick next ready.
  initial begin
    out_ready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_node({out_pos, {out_alpha, out_blue, out_green, out_red}, out_last});
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 1500;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(logic [31:0] sh, logic [31:0] l, logic [31:0] h,
                              logic [16:0] w, color_t lc);
    cfg_write(CFG_SHIFT, sh);
    cfg_write(CFG_RANGE_LO, l);
    cfg_write(CFG_RANGE_HI, h);
    cfg_write(CFG_RAMP_WIDTH, {15'd0, w});
    cfg_write(CFG_LOW_RED, {16'd0, lc[0]});
    cfg_write(CFG_LOW_GREEN, {16'd0, lc[1]});
    cfg_write(CFG_LOW_BLUE, {16'd0, lc[2]});
    cfg_write(CFG_LOW_ALPHA, {16'd0, lc[3]});
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] pp, color_t c, logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_pos <= pp;
    {point_alpha, point_blue, point_green, point_red} <= c;
    last_point <= lst;
    do @(posedge clk); while (!in_ready);
    sb.note_point(pp, c, lst);
    prev_pos = pp;
    prev_col = c;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.nodes_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Aim most positions at the configured window, with some spill on each side.
  function automatic logic [31:0] pick_pos();
    longint span, r;
    span = longint'($signed(sb.hi)) - longint'($signed(sb.lo));
    if (span <= 0 || $urandom_range(9) == 0) return $urandom;
    r = longint'($urandom_range(81536)) - 8000;
    return 32'(longint'($signed(sb.lo)) - longint'($signed(sb.shift)) +
               (span * r) / OneQ16);
  endfunction

  task automatic send_set(int n);
    logic [31:0] pp;
    color_t c;
    for (int i = 0; i < n; i++) begin
      pp = pick_pos();
      c = {$urandom, $urandom};
      if (i > 0) begin
        case ($urandom_range(7))
          0: begin pp = prev_pos; c = prev_col; end
          1: pp = prev_pos;
          2: pp = prev_pos + $urandom_range(3 * sb.width);
          default: ;
        endcase
      end
      send_point(pp, c, i == n - 1);
    end
  endtask

  initial begin
    logic [31:0] dpos[17];
    color_t c;
    int sent, n;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    point_pos = '0;
    {point_alpha, point_blue, point_green, point_red} = '0;
    last_point = 1'b0;
    send_idle = 7;
    recv_idle = 65;
    hold_req = 1'b0;
    cycles = 0;
    sb.set_reg(CFG_SHIFT, 0);
    sb.set_reg(CFG_RANGE_LO, 0);
    sb.set_reg(CFG_RANGE_HI, 32'h10000);
    sb.set_reg(CFG_RAMP_WIDTH, 6554);
    sb.low = '0;
    sb.cnt = 0;
    sb.errors = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apply_config(0, 0, 32'h10000, 17'd6554, '0);

    // Overflowing set: extremes, ties, exact duplicate, close and wide peaks;
    // the dropped 17th point still closes the set.
    dpos = '{32'h7FFFFFFF, 32'h80000000, 0, 32'h10000, 32'h8000, 32'h8000, 32'h8000,
             10000, 12000, 40000, 50000, 1, 65535, 20000, 21000, 30000, 5000};
    for (int i = 0; i < 17; i++) begin
      c = (i % 2) ? {4{16'hFFFF}} : {$urandom, $urandom};
      if (i == 5) c = prev_col;
      if (i < 2) c = i ? '0 : {4{16'hFFFF}};
      send_point(dpos[i], c, i == 16);
    end
    send_point(0, {4{16'h1234}}, 1'b1);
    send_point(32'h10000, {4{16'hFFFF}}, 1'b1);
    send_point(20000, {16'hFFFF, 16'h0, 16'h8000, 16'h7FFF}, 1'b0);
    send_point(30000, {16'h0, 16'hFFFF, 16'h1, 16'hFFFE}, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 7 : (ph < 4) ? 65 : 0;
      recv_idle = (ph < 2) ? 65 : (ph < 4) ? 7 : 0;
      case (ph)
        0: apply_config(0, 0, 32'h10000, 17'd6554, '0);
        1: apply_config(32'hFFFF8000, 32'h80000000, 32'h7FFFFFFF, 17'h10000,
                        {4{16'hFFFF}});
        2: apply_config($urandom, 32'h5, 32'h5, 17'd0, {$urandom, $urandom});
        3: apply_config(32'h7FFFFFFF, 32'h7FFF0000, 32'h7FFFFFFF, 17'd1,
                        {$urandom, $urandom});
        4: apply_config($urandom_range(200000), 32'hFFFE0000, 32'h00030000,
                        17'h1FFFF, {$urandom, $urandom});
        default: apply_config(32'h80000000, 32'hFFFFFFFF, 32'h80000000, 17'd2000,
                              {$urandom, $urandom});
      endcase
      if (ph == 4) hold_req = 1'b1;
      sent = 0;
      while (sent < 20) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
        send_set(n);
        sent += n;
      end
      drain();
    end

    if (sb.errors == 0 && sb.nodes_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
